>>> hdl/sle_pkg.sv
// Package for the sorted list engine: command codes, widths and the
// structs that pass between the list cells. No dependencies.
package sle_pkg;

	localparam int unsigned DEF_CAPACITY = 16;
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned COUNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_POP    = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	// Contents of one list position.
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] val;
	} entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic              fire;
		logic              full;
		cmd_t              cmd;
		logic [DATA_W-1:0] value;
	} bcast_t;

	// Running state handed from each cell to the next one toward the tail.
	typedef struct packed {
		logic              hit;
		logic              got;
		logic [DATA_W-1:0] taken;
	} chain_t;

endpackage

>>> hdl/sle_cell.sv
// One position of the sorted list engine: stores an entry and shifts it
// toward its neighbors on insert and remove. Depends on sle_pkg.
module sle_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  sle_pkg::bcast_t bcast,
	input  sle_pkg::entry_t left,
	input  sle_pkg::entry_t right,
	input  sle_pkg::chain_t chain_in,
	output sle_pkg::chain_t chain_out,
	output sle_pkg::entry_t cur
);

	logic            vld_q;
	logic [sle_pkg::DATA_W-1:0] val_q;
	logic            lt;
	logic            eq;
	logic            stop;
	logic            here;
	logic            take;
	sle_pkg::entry_t nxt;

	assign cur.vld = vld_q;
	assign cur.val = val_q;

	always_comb begin
		lt   = vld_q && ($signed(val_q) < $signed(bcast.value));
		eq   = vld_q && (val_q == bcast.value);
		stop = 1'b0;
		unique case (bcast.cmd)
			sle_pkg::CMD_INSERT: stop = !lt;
			sle_pkg::CMD_APPEND: stop = 1'b0;
			sle_pkg::CMD_POP:    stop = 1'b1;
			sle_pkg::CMD_REMOVE: stop = eq;
			default:             stop = 1'b0;
		endcase
		here = stop && !chain_in.hit;
		take = here && vld_q &&
			(bcast.cmd == sle_pkg::CMD_POP || bcast.cmd == sle_pkg::CMD_REMOVE);

		chain_out.hit   = chain_in.hit || stop;
		chain_out.got   = chain_in.got || take;
		chain_out.taken = chain_in.taken | (take ? val_q : '0);

		nxt = cur;
		unique case (bcast.cmd)
			sle_pkg::CMD_INSERT: begin
				if (!bcast.full) begin
					if (here) begin
						nxt.vld = 1'b1;
						nxt.val = bcast.value;
					end else if (chain_in.hit) begin
						nxt = left;
					end
				end
			end
			sle_pkg::CMD_APPEND: begin
				if (!bcast.full && !vld_q && left.vld) begin
					nxt.vld = 1'b1;
					nxt.val = bcast.value;
				end
			end
			sle_pkg::CMD_POP: begin
				nxt = right;
			end
			sle_pkg::CMD_REMOVE: begin
				if (chain_out.hit) begin
					nxt = right;
				end
			end
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (bcast.fire) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.fire) begin
			val_q <= nxt.val;
		end
	end

endmodule

>>> hdl/sorted_list_engine.sv
// Sorted list engine: a priority queue of signed 32-bit values held in a
// row of sle_cell instances. Depends on sle_pkg and sle_cell.
//
// Usage: one command beat on the input channel (cmd, value) gives one
// result beat on the output channel. Commands are sorted insert (placed
// before the first entry not smaller than the value), append at the tail,
// remove first, and remove the first entry equal to the value.
// Every cell compares its entry with the broadcast value in the cycle a
// beat is accepted, and all cells shift together at that edge, so one
// command is taken per cycle while in_stall is low. The result beat of a
// command passes one stage for the list update, then one output register.
// The result reports the removed value and found flag, the head and count
// after the command, and overflow when an insert or append met a full list
// (the value is then dropped).
// When the receiver stalls, one further command can still be accepted and
// held in the middle stage; after that in_stall rises until the output
// register drains. Reset empties the list and clears both result stages.
module sorted_list_engine #(
	parameter int unsigned CAPACITY = sle_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        cmd,
	input  logic signed [sle_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [sle_pkg::DATA_W-1:0] removed_value,
	output logic                              found,
	output logic signed [sle_pkg::DATA_W-1:0] head_value,
	output logic [sle_pkg::COUNT_OUT_W-1:0]   entry_count,
	output logic                              overflow
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = (CW > sle_pkg::COUNT_OUT_W) ? CW : sle_pkg::COUNT_OUT_W;

	sle_pkg::entry_t cells  [CAPACITY];
	sle_pkg::chain_t chains [CAPACITY+1];
	sle_pkg::bcast_t bcast;

	logic          fire;
	logic          advance;
	logic          grow;
	logic [CW-1:0] count_q;
	logic [EW-1:0] count_ext;

	logic                       vld_s1;
	logic [sle_pkg::DATA_W-1:0] removed_s1;
	logic                       found_s1;
	logic                       ovf_s1;

	logic                       out_valid_q;
	logic [sle_pkg::DATA_W-1:0] removed_q;
	logic                       found_q;
	logic [sle_pkg::DATA_W-1:0] head_q;
	logic [sle_pkg::COUNT_OUT_W-1:0] count_out_q;
	logic                       ovf_q;

	assign advance  = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;

	assign bcast.fire  = fire;
	assign bcast.full  = cells[CAPACITY-1].vld;
	assign bcast.cmd   = sle_pkg::cmd_t'(cmd);
	assign bcast.value = value;

	assign chains[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sle_pkg::entry_t left_e;
		sle_pkg::entry_t right_e;
		if (i == 0) begin : g_first
			assign left_e.vld = 1'b1;
			assign left_e.val = '0;
		end else begin : g_mid_l
			assign left_e = cells[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = cells[i+1];
		end
		sle_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast),
			.left      (left_e),
			.right     (right_e),
			.chain_in  (chains[i]),
			.chain_out (chains[i+1]),
			.cur       (cells[i])
		);
	end

	assign grow = !bcast.full &&
		(bcast.cmd == sle_pkg::CMD_INSERT || bcast.cmd == sle_pkg::CMD_APPEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			if (grow) begin
				count_q <= count_q + CW'(1);
			end else if (chains[CAPACITY].got) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			removed_s1 <= chains[CAPACITY].taken;
			found_s1   <= chains[CAPACITY].got;
			ovf_s1     <= bcast.full &&
				(bcast.cmd == sle_pkg::CMD_INSERT || bcast.cmd == sle_pkg::CMD_APPEND);
		end
	end

	assign count_ext = EW'(count_q);

	always_ff @(posedge clk) begin
		if (advance) begin
			removed_q   <= removed_s1;
			found_q     <= found_s1;
			ovf_q       <= ovf_s1;
			head_q      <= cells[0].vld ? cells[0].val : '0;
			count_out_q <= count_ext[sle_pkg::COUNT_OUT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign found         = found_q;
	assign head_value    = head_q;
	assign entry_count   = count_out_q;
	assign overflow      = ovf_q;

endmodule

>>> verif/sorted_list_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_engine: a directed table, then random command
// streams under varied input gaps and output stalls, checked against a queue-based predictor.
// Depends on sle_pkg and the sorted_list_engine RTL.
module sorted_list_engine_tb;

	localparam int unsigned CAPACITY = sle_pkg::DEF_CAPACITY;
	localparam int RANDOM_PER_PHASE = 231;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int MAX_REPORTS = 10;
	localparam logic signed [sle_pkg::DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [sle_pkg::DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;

	typedef enum int {TIDE_FILL, TIDE_DRAIN, TIDE_EVEN} tide_t;

	typedef struct packed {
		logic signed [sle_pkg::DATA_W-1:0] removed_value;
		logic                              found;
		logic signed [sle_pkg::DATA_W-1:0] head_value;
		logic [sle_pkg::COUNT_OUT_W-1:0]   entry_count;
		logic                              overflow;
	} list_result_t;

	typedef struct {
		sle_pkg::cmd_t                     op;
		logic signed [sle_pkg::DATA_W-1:0] arg;
		bit                                typed;
		list_result_t                      want;
	} stim_row_t;

	typedef struct {
		bit           typed;
		list_result_t want;
	} row_check_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        cmd = 2'd0;
	logic signed [sle_pkg::DATA_W-1:0] value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [sle_pkg::DATA_W-1:0] removed_value;
	logic                              found;
	logic signed [sle_pkg::DATA_W-1:0] head_value;
	logic [sle_pkg::COUNT_OUT_W-1:0]   entry_count;
	logic                              overflow;

	logic signed [sle_pkg::DATA_W-1:0] list_q[$];
	list_result_t                      pending_results[$];
	row_check_t                        typed_checks[$];
	stim_row_t                         directed_rows[25];
	int                                cmds_accepted = 0;
	int                                results_taken = 0;
	int                                mismatches = 0;
	int                                quiet_cycles = 0;
	int                                idle_pct = 0;
	int                                stall_pct = 0;
	int                                holds_asked = 0;
	int                                holds_done = 0;

	sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.removed_value(removed_value),
		.found(found),
		.head_value(head_value),
		.entry_count(entry_count),
		.overflow(overflow)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	function automatic list_result_t apply_command(sle_pkg::cmd_t op,
			logic signed [sle_pkg::DATA_W-1:0] arg);
		list_result_t r;
		int pos;
		r = '0;
		pos = 0;
		case (op) inside
			sle_pkg::CMD_INSERT, sle_pkg::CMD_APPEND: begin
				if (list_q.size() >= CAPACITY) begin
					r.overflow = 1'b1;
				end else if (op == sle_pkg::CMD_APPEND) begin
					list_q.push_back(arg);
				end else begin
					while (pos < list_q.size() && list_q[pos] < arg)
						pos++;
					list_q.insert(pos, arg);
				end
			end
			sle_pkg::CMD_POP: begin
				if (list_q.size() > 0) begin
					r.removed_value = list_q.pop_front();
					r.found = 1'b1;
				end
			end
			sle_pkg::CMD_REMOVE: begin
				while (pos < list_q.size() && list_q[pos] != arg)
					pos++;
				if (pos < list_q.size()) begin
					r.removed_value = list_q[pos];
					list_q.delete(pos);
					r.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.head_value = (list_q.size() > 0) ? list_q[0] : '0;
		r.entry_count = sle_pkg::COUNT_OUT_W'(list_q.size());
		return r;
	endfunction

	function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 32'($urandom_range(8)) - 32'd4;
		if (roll < 70) begin
			case ($urandom_range(4))
				0: return S_MIN;
				1: return S_MAX;
				2: return 32'sd0;
				3: return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic sle_pkg::cmd_t pick_cmd(tide_t tide);
		int unsigned grow_pct;
		grow_pct = (tide == TIDE_FILL) ? 70 : (tide == TIDE_DRAIN) ? 30 : 50;
		if ($urandom_range(99) < grow_pct)
			return ($urandom_range(3) == 0) ? sle_pkg::CMD_APPEND : sle_pkg::CMD_INSERT;
		return $urandom_range(1) ? sle_pkg::CMD_REMOVE : sle_pkg::CMD_POP;
	endfunction

	task automatic drive_item(sle_pkg::cmd_t op, logic signed [sle_pkg::DATA_W-1:0] arg,
			bit typed, list_result_t want);
		row_check_t chk;
		chk.typed = typed;
		chk.want = want;
		typed_checks.push_back(chk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		value <= arg;
		do @(posedge clk); while (in_stall);
		cmds_accepted++;
	endtask

	// Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		row_check_t chk;
		list_result_t r;
		if (arst_n && in_valid && !in_stall) begin
			r = apply_command(sle_pkg::cmd_t'(cmd), value);
			chk = typed_checks.pop_front();
			pending_results.push_back(chk.typed ? chk.want : r);
		end
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{removed_value, found, head_value, entry_count, overflow};
			results_taken++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"Result beat with nothing expected: removed %0d found %b",
						" head %0d count %0d overflow %b"},
						got.removed_value, got.found, got.head_value, got.entry_count,
						got.overflow);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"Mismatch on result %0d: removed %0d/%0d found %b/%b",
							" head %0d/%0d count %0d/%0d overflow %b/%b (expected/actual)"},
							results_taken, want.removed_value, got.removed_value,
							want.found, got.found, want.head_value, got.head_value,
							want.entry_count, got.entry_count, want.overflow, got.overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("sorted_list_engine_tb: FAIL");
			$finish;
		end
	end

	initial begin
		tide_t tide;
		int tide_left;
		directed_rows = '{
			'{sle_pkg::CMD_POP,    32'sd0,     1'b1, '{32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0}},
			'{sle_pkg::CMD_REMOVE, 32'sd5,     1'b1, '{32'sd0, 1'b0, 32'sd0, 5'd0, 1'b0}},
			'{sle_pkg::CMD_INSERT, S_MAX,      1'b1, '{32'sd0, 1'b0, S_MAX, 5'd1, 1'b0}},
			'{sle_pkg::CMD_INSERT, S_MIN,      1'b1, '{32'sd0, 1'b0, S_MIN, 5'd2, 1'b0}},
			'{sle_pkg::CMD_INSERT, 32'sd0,     1'b1, '{32'sd0, 1'b0, S_MIN, 5'd3, 1'b0}},
			'{sle_pkg::CMD_INSERT, -32'sd1,    1'b0, '0},
			'{sle_pkg::CMD_APPEND, -32'sd5,    1'b0, '0},
			'{sle_pkg::CMD_INSERT, 32'sd0,     1'b0, '0},
			'{sle_pkg::CMD_REMOVE, 32'sd12345, 1'b0, '0},
			'{sle_pkg::CMD_REMOVE, 32'sd0,     1'b0, '0},
			'{sle_pkg::CMD_POP,    32'sd0,     1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh0000_0001, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'shFFFF_FFFE, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh1234_5678, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'shEDCB_A987, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh5555_5555, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'shAAAA_AAAA, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh0F0F_0F0F, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'shF0F0_F0F0, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh7FFF_FFFE, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh8000_0001, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'sh0000_0100, 1'b0, '0},
			'{sle_pkg::CMD_APPEND, 32'shFFFF_FF00, 1'b0, '0},
			'{sle_pkg::CMD_INSERT, 32'sd7, 1'b1, '{32'sd0, 1'b0, -32'sd1, 5'd16, 1'b1}},
			'{sle_pkg::CMD_APPEND, 32'sd7, 1'b1, '{32'sd0, 1'b0, -32'sd1, 5'd16, 1'b1}}
		};
		tide = TIDE_EVEN;
		tide_left = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i].op, directed_rows[i].arg, directed_rows[i].typed,
				directed_rows[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (tide_left == 0) begin
					tide = tide_t'($urandom_range(2));
					tide_left = $urandom_range(20, 60);
				end
				tide_left--;
				if (phase == 0 && n == 80)
					holds_asked++;
				if (phase == 0 && n == 160) begin
					in_valid <= 1'b0;
					wait (results_taken == cmds_accepted);
					@(posedge clk);
				end
				drive_item(pick_cmd(tide), pick_value(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		wait (results_taken == cmds_accepted);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0d expected results never arrived", pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("sorted_list_engine_tb: PASS");
		end else begin
			$display("sorted_list_engine_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sorted_list_engine.sv
verif/sorted_list_engine_tb.sv
